// File: rtl/assert_macros.svh
// Assertion macros shared by the pending event queue RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted (active low)
`define PEQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Clocked check that also holds during reset
`define PEQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define PEQ_ASSERT(name, clk, rst_n, prop)
`define PEQ_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: rtl/peq_pkg.sv
// Types and constants of the pending event queue.
// No dependencies; imported by every module and interface of the block.
package peq_pkg;

  localparam int FUNC_W     = 3;
  localparam int CODE_W     = 8;
  localparam int POS_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int LIMIT_RESET = 20;
  localparam int LIMIT_MIN   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ    = 3'd0,
    FN_DEQ    = 3'd1,
    FN_CANCEL = 3'd2,
    FN_SETEN  = 3'd3,
    FN_SCAN   = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT    = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_FINALIZE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] timeout_code;
    logic [CODE_W-1:0] finalize_code;
  } peq_codes_t;

endpackage

// File: rtl/peq_if.sv
// Valid/ready channel interfaces for operation requests and results.
// Depends on peq_pkg for field widths.
interface peq_in_if
  import peq_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [CODE_W-1:0]       event_code;
  logic [PAYLOAD_BITS-1:0] event_payload;
  logic                    payload_is_ref;
  logic                    enable_value;
  logic [POS_W-1:0]        scan_start;

  modport source (output valid, func, event_code, event_payload, payload_is_ref,
                  enable_value, scan_start, input ready);
  modport sink   (input valid, func, event_code, event_payload, payload_is_ref,
                  enable_value, scan_start, output ready);
endinterface

interface peq_out_if
  import peq_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [CODE_W-1:0]       out_code;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    out_is_ref;
  logic                    old_enable;
  logic [POS_W-1:0]        next_position;
  logic                    ready_now;
  logic [POS_W-1:0]        entries_held;

  modport source (output valid, status, out_code, out_payload, out_is_ref, old_enable,
                  next_position, ready_now, entries_held, input ready);
  modport sink   (input valid, status, out_code, out_payload, out_is_ref, old_enable,
                  next_position, ready_now, entries_held, output ready);
endinterface

// File: rtl/peq_ram.sv
// Entry store: single write port, single read port, registered read data.
// Depends on peq_pkg only through the common import style.
module peq_ram
  import peq_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int WIDTH = 41
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write the entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/peq_cfg.sv
// Configuration registers: queue limit with adjustment, timeout and finalize codes.
// Depends on peq_pkg for register indexes and widths.
module peq_cfg
  import peq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH+1)-1:0] limit,
  output peq_codes_t                 codes
);

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LIM_RST = (LIMIT_RESET > DEPTH) ? DEPTH : LIMIT_RESET;

  logic [CNT_W-1:0] limit_r, limit_nxt;
  peq_codes_t       codes_r, codes_nxt;
  logic [CMP_W-1:0] req_lim;
  logic [CMP_W-1:0] adj_lim;

  // Raise the written limit to the minimum and to the count, cap at depth
  always_comb begin
    req_lim = CMP_W'(cfg_wdata[POS_W-1:0]);
    adj_lim = req_lim;
    if (adj_lim < CMP_W'(LIMIT_MIN)) begin
      adj_lim = CMP_W'(LIMIT_MIN);
    end
    if (adj_lim < CMP_W'(count)) begin
      adj_lim = CMP_W'(count);
    end
    if (adj_lim > CMP_W'(DEPTH)) begin
      adj_lim = CMP_W'(DEPTH);
    end
  end

  // Decode the register index
  always_comb begin
    limit_nxt = limit_r;
    codes_nxt = codes_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LIMIT:    limit_nxt = CNT_W'(adj_lim);
        CFG_TIMEOUT:  codes_nxt.timeout_code = cfg_wdata[CODE_W-1:0];
        CFG_FINALIZE: codes_nxt.finalize_code = cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r                <= CNT_W'(LIM_RST);
      codes_r.timeout_code   <= CODE_W'(1);
      codes_r.finalize_code  <= CODE_W'(2);
    end else begin
      limit_r <= limit_nxt;
      codes_r <= codes_nxt;
    end
  end

  assign limit = limit_r;
  assign codes = codes_r;

endmodule

// File: rtl/peq_ctrl.sv
// Queue sequencer: circular addressing, entry walks over the RAM and result staging.
// Depends on peq_pkg, peq_if and assert_macros.svh; drives peq_ram.
`include "assert_macros.svh"
module peq_ctrl
  import peq_pkg::*;
#(
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  peq_in_if.sink                                in_ch,
  peq_out_if.source                             out_ch,
  input  logic [$clog2(DEPTH+1)-1:0]            limit,
  input  peq_codes_t                            codes,
  output logic [$clog2(DEPTH+1)-1:0]            count,
  output logic                                  ram_we,
  output logic [$clog2(DEPTH)-1:0]              ram_waddr,
  output logic [CODE_W+PAYLOAD_BITS:0]          ram_wdata,
  output logic [$clog2(DEPTH)-1:0]              ram_raddr,
  input  logic [CODE_W+PAYLOAD_BITS:0]          ram_rdata
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W = CODE_W + PAYLOAD_BITS + 1;

  // Map a queue position to a RAM address relative to the head
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    en_r, en_nxt;
  logic                    rdy_r, rdy_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]        chk_idx_r, chk_idx_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic                    is_scan_r, is_scan_nxt;

  status_t                 res_status_r, res_status_nxt;
  logic [CODE_W-1:0]       res_code_r, res_code_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;
  logic                    res_ref_r, res_ref_nxt;
  logic                    res_olden_r, res_olden_nxt;
  logic [POS_W-1:0]        res_pos_r, res_pos_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_load;
  status_t                 out_status_r;
  logic [CODE_W-1:0]       out_code_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic                    out_ref_r;
  logic                    out_olden_r;
  logic [POS_W-1:0]        out_pos_r;
  logic                    out_rdy_r;
  logic [POS_W-1:0]        out_held_r;

  logic                    in_xfer;
  logic                    rd_en;
  logic                    hit;
  logic [CODE_W-1:0]       rd_code;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    rd_ref;
  logic [CNT_W-1:0]        count_dec;
  logic [CMP_W-1:0]        start_ext;

  assign rd_code   = ram_rdata[CODE_W-1:0];
  assign rd_pay    = ram_rdata[CODE_W +: PAYLOAD_BITS];
  assign rd_ref    = ram_rdata[DATA_W-1];
  assign count_dec = count_r - CNT_W'(1);
  assign start_ext = CMP_W'(in_ch.scan_start);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  // Match of the entry read in the previous cycle
  assign hit = chk_vld_r &&
               (is_scan_r ? ((rd_code == codes.finalize_code) && rd_ref)
                          : (rd_code == codes.timeout_code));

  // Sequence each operation and drive the RAM ports
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    en_nxt         = en_r;
    rdy_nxt        = rdy_r;
    rd_idx_nxt     = rd_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    is_scan_nxt    = is_scan_r;
    res_status_nxt = res_status_r;
    res_code_nxt   = res_code_r;
    res_pay_nxt    = res_pay_r;
    res_ref_nxt    = res_ref_r;
    res_olden_nxt  = res_olden_r;
    res_pos_nxt    = res_pos_r;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, count_r);
    ram_wdata      = {in_ch.payload_is_ref, in_ch.event_payload, in_ch.event_code};
    ram_raddr      = head_r;
    rd_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_nxt = ST_OK;
          res_code_nxt   = '0;
          res_pay_nxt    = '0;
          res_ref_nxt    = 1'b0;
          res_olden_nxt  = 1'b0;
          res_pos_nxt    = '0;
          state_nxt      = S_FINISH;
          case (func_t'(in_ch.func))
            FN_ENQ: begin
              if ((count_r >= limit) || (count_r >= CNT_W'(DEPTH))) begin
                res_status_nxt = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (en_r) begin
                  rdy_nxt = 1'b1;
                end
              end
            end
            FN_DEQ: begin
              en_nxt  = 1'b0;
              rdy_nxt = 1'b0;
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            FN_CANCEL: begin
              is_scan_nxt = 1'b0;
              rd_idx_nxt  = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = S_SEARCH;
            end
            FN_SETEN: begin
              res_olden_nxt = en_r;
              en_nxt        = in_ch.enable_value;
              rdy_nxt       = in_ch.enable_value && (count_r != '0);
            end
            FN_SCAN: begin
              is_scan_nxt = 1'b1;
              chk_vld_nxt = 1'b0;
              rd_idx_nxt  = (start_ext > CMP_W'(count_r)) ? count_r
                                                           : CNT_W'(in_ch.scan_start);
              state_nxt   = S_SEARCH;
            end
            default: ;
          endcase
        end
      end

      S_DEQ: begin
        // Take the head and advance it
        res_code_nxt = rd_code;
        res_pay_nxt  = rd_pay;
        res_ref_nxt  = rd_ref;
        head_nxt     = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
        count_nxt    = count_dec;
        state_nxt    = S_FINISH;
      end

      S_SEARCH: begin
        if (hit) begin
          if (is_scan_r) begin
            res_pay_nxt = rd_pay;
            res_pos_nxt = POS_W'(chk_idx_r + CNT_W'(1));
            state_nxt   = S_FINISH;
          end else begin
            // Close the gap behind the matching entry
            rd_idx_nxt  = chk_idx_r + CNT_W'(1);
            chk_vld_nxt = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end else if (rd_idx_r < count_r) begin
          rd_en       = 1'b1;
          ram_raddr   = phys(head_r, rd_idx_r);
          chk_idx_nxt = rd_idx_r;
          chk_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end else begin
          res_status_nxt = ST_NOT_FOUND;
          chk_vld_nxt    = 1'b0;
          if (is_scan_r) begin
            res_pos_nxt = POS_W'(count_r);
          end else if (count_r == '0) begin
            rdy_nxt = 1'b0;
          end
          state_nxt = S_FINISH;
        end
      end

      S_SHIFT: begin
        // Move each later entry one place forward
        if (chk_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, chk_idx_r - CNT_W'(1));
          ram_wdata = ram_rdata;
        end
        if (rd_idx_r < count_r) begin
          rd_en       = 1'b1;
          ram_raddr   = phys(head_r, rd_idx_r);
          chk_idx_nxt = rd_idx_r;
          chk_vld_nxt = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            count_nxt = count_dec;
            if (count_dec == '0) begin
              rdy_nxt = 1'b0;
            end
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      en_r        <= 1'b1;
      rdy_r       <= 1'b0;
      rd_idx_r    <= '0;
      chk_idx_r   <= '0;
      chk_vld_r   <= 1'b0;
      is_scan_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      en_r        <= en_nxt;
      rdy_r       <= rdy_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_idx_r   <= chk_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      is_scan_r   <= is_scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result staging and output registers
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_code_r   <= res_code_nxt;
    res_pay_r    <= res_pay_nxt;
    res_ref_r    <= res_ref_nxt;
    res_olden_r  <= res_olden_nxt;
    res_pos_r    <= res_pos_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_code_r   <= res_code_r;
      out_pay_r    <= res_pay_r;
      out_ref_r    <= res_ref_r;
      out_olden_r  <= res_olden_r;
      out_pos_r    <= res_pos_r;
      out_rdy_r    <= rdy_r;
      out_held_r   <= POS_W'(count_r);
    end
  end

  assign count                = count_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_code      = out_code_r;
  assign out_ch.out_payload   = out_pay_r;
  assign out_ch.out_is_ref    = out_ref_r;
  assign out_ch.old_enable    = out_olden_r;
  assign out_ch.next_position = out_pos_r;
  assign out_ch.ready_now     = out_rdy_r;
  assign out_ch.entries_held  = out_held_r;

  `PEQ_ASSERT(a_rdy_nonempty, clk, rst_n, rdy_r |-> (count_r != '0))
  `PEQ_ASSERT(a_count_in_limit, clk, rst_n, count_r <= limit)
  `PEQ_ASSERT(a_enq_grows, clk, rst_n, (in_xfer && (func_t'(in_ch.func) == FN_ENQ) && (count_r < limit)) |=> (count_r == $past(count_r) + CNT_W'(1)))
  `PEQ_ASSERT(a_shift_no_clash, clk, rst_n, (state_r == S_SHIFT && ram_we && rd_en) |-> (ram_waddr != ram_raddr))
  `PEQ_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_FINISH))

endmodule

// File: rtl/pending_event_queue.sv
// Top level of the pending event queue: configuration, sequencer and entry RAM.
// Depends on peq_pkg, peq_if, peq_cfg, peq_ctrl and peq_ram.
//
//   channel   direction  handshake        contents
//   in_ch     sink       valid/ready      func, event fields, enable_value, scan_start
//   out_ch    source     valid/ready      status, dequeued/found entry, flags, count
//   cfg_*     sink       write enable     register index and write data, no read-back
//
// One operation at a time; enqueue, set enable and unused codes pass from the transfer
// through S_FINISH to the output register, dequeue through S_DEQ and S_FINISH.
// Scan reads one entry per cycle through the single RAM read port.
// Cancel searches, then moves each later entry forward one per cycle.
// Reset: synchronous on rst_n, empty queue, enable set, ready clear, no clearing pass.
// A result waiting on out_ch does not block the next input transfer; a second result
// waits in the sequencer until the output register frees.
module pending_event_queue
  import peq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  peq_in_if.sink                in_ch,
  peq_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W = CODE_W + PAYLOAD_BITS + 1;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  limit;
  peq_codes_t        codes;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Configuration registers
  peq_cfg #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .count     (count),
    .limit     (limit),
    .codes     (codes)
  );

  // Operation sequencer
  peq_ctrl #(
    .DEPTH        (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .limit     (limit),
    .codes     (codes),
    .count     (count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Entry store
  peq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
